// ----- design/double_ended_queue_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ----- design/deq_pkg.sv -----
// ---------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes and the response record passed between modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_PUSH_HEAD = 3'd0;
	localparam cmd_t CMD_PUSH_TAIL = 3'd1;
	localparam cmd_t CMD_POP_HEAD  = 3'd2;
	localparam cmd_t CMD_POP_TAIL  = 3'd3;
	localparam cmd_t CMD_READ      = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam int DATA_OUT_W  = 32;
	localparam int PUSH_W      = 32;
	localparam int POSITION_W  = 8;
	localparam int OCCUPANCY_W = 9;

	// Outcome of one transaction, decided at acceptance.
	typedef struct packed {
		logic                   is_read;
		status_t                status;
		logic [OCCUPANCY_W-1:0] occupancy;
	} deq_resp_t;

endpackage

`default_nettype wire

// ----- design/deq_ram.sv -----
// ---------------------------------------------------------------------------
// Deque storage
// Single-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/deq_ctrl.sv -----
// ---------------------------------------------------------------------------
// Deque pointer control
// Keeps the head slot and element count, decodes each command into at most
// one RAM access and the status and occupancy of its result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
	parameter int DEPTH      = 256,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire deq_pkg::cmd_t                       command,
	input  wire logic [deq_pkg::PUSH_W-1:0]          push_word,
	input  wire logic [deq_pkg::POSITION_W-1:0]      position,
	output logic                                     mem_we,
	output logic                                     mem_re,
	output logic      [$clog2(DEPTH)-1:0]            mem_addr,
	output logic      [WORD_WIDTH-1:0]               mem_wdata,
	output deq_pkg::deq_resp_t                       resp
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > deq_pkg::POSITION_W) ? CNT_W : deq_pkg::POSITION_W;

	logic [PTR_W-1:0] head_q, head_d, head_dec, head_inc, slot_sum, addr_d;
	logic [CNT_W-1:0] count_q, count_d, offset;
	logic [SUM_W-1:0] sum_raw;
	logic [CMP_W-1:0] pos_ext, count_ext;
	logic             full, empty, in_range, we_d, re_d, is_read;
	deq_pkg::status_t status;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign pos_ext   = CMP_W'(position);
	assign count_ext = CMP_W'(count_q);
	assign in_range  = (pos_ext < count_ext);

	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	// Offsets used for a RAM access never exceed the count, so one conditional subtract wraps the sum.
	always_comb begin
		if (command == deq_pkg::CMD_PUSH_TAIL) begin
			offset = count_q;
		end else if (command == deq_pkg::CMD_POP_TAIL) begin
			offset = count_q - CNT_W'(1);
		end else begin
			offset = CNT_W'(pos_ext);
		end
	end

	assign sum_raw  = SUM_W'(head_q) + SUM_W'(offset);
	assign slot_sum = (sum_raw >= SUM_W'(DEPTH)) ? PTR_W'(sum_raw - SUM_W'(DEPTH))
	                                             : PTR_W'(sum_raw);

	always_comb begin
		we_d    = 1'b0;
		re_d    = 1'b0;
		is_read = 1'b0;
		status  = deq_pkg::ST_OK;
		addr_d  = slot_sum;
		head_d  = head_q;
		count_d = count_q;
		case (command)
			deq_pkg::CMD_PUSH_HEAD: begin
				if (full) begin
					status = deq_pkg::ST_FULL;
				end else begin
					we_d    = 1'b1;
					addr_d  = head_dec;
					head_d  = head_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			deq_pkg::CMD_PUSH_TAIL: begin
				if (full) begin
					status = deq_pkg::ST_FULL;
				end else begin
					we_d    = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			deq_pkg::CMD_POP_HEAD: begin
				if (empty) begin
					status = deq_pkg::ST_EMPTY;
				end else begin
					re_d    = 1'b1;
					is_read = 1'b1;
					addr_d  = head_q;
					head_d  = head_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			deq_pkg::CMD_POP_TAIL: begin
				if (empty) begin
					status = deq_pkg::ST_EMPTY;
				end else begin
					re_d    = 1'b1;
					is_read = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			deq_pkg::CMD_READ: begin
				if (!in_range) begin
					status = deq_pkg::ST_RANGE;
				end else begin
					re_d    = 1'b1;
					is_read = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we    = accept & we_d;
	assign mem_re    = accept & re_d;
	assign mem_addr  = addr_d;
	assign mem_wdata = WORD_WIDTH'(push_word);

	assign resp.is_read   = is_read;
	assign resp.status    = status;
	assign resp.occupancy = deq_pkg::OCCUPANCY_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// ---------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque with push and pop at both ends and indexed read.
// ---------------------------------------------------------------------------
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  cmd     | cmd_valid, cmd_ready, command, push_word,| in
//          | position                                 |
//  rsp     | rsp_valid, rsp_ready, data_out, status,  | out
//          | occupancy                                |
//
// One command is taken every cycle while responses drain; the single RAM port
// serves the single access a command may make, so the pointers never wait.
// The RAM read and the response record are registered at the accepting edge;
// the response register loads from them when the read stage advances.
// Reset clears the head slot, count and valid flags; the RAM is not cleared.
// With rsp_ready low one more command can be held in the read stage, after
// which cmd_ready drops until the response register empties.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH      = 256,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_ready,
	input  wire deq_pkg::cmd_t                     command,
	input  wire logic [deq_pkg::PUSH_W-1:0]        push_word,
	input  wire logic [deq_pkg::POSITION_W-1:0]    position,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output logic      [deq_pkg::DATA_OUT_W-1:0]    data_out,
	output deq_pkg::status_t                       status,
	output logic      [deq_pkg::OCCUPANCY_W-1:0]   occupancy
);

	logic                     accept, advance, mem_we, mem_re;
	logic [$clog2(DEPTH)-1:0] mem_addr;
	logic [WORD_WIDTH-1:0]    mem_wdata, mem_rdata;
	deq_pkg::deq_resp_t       resp, resp_s1;
	logic                     valid_s1;

	logic                                 rsp_valid_q;
	logic [deq_pkg::DATA_OUT_W-1:0]       data_q;
	deq_pkg::status_t                     status_q;
	logic [deq_pkg::OCCUPANCY_W-1:0]      occupancy_q;

	// The read stage moves on whenever the response register is free or draining.
	assign advance   = !rsp_valid_q || rsp_ready;
	assign cmd_ready = !valid_s1 || advance;
	assign accept    = cmd_valid && cmd_ready;

	deq_ctrl #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (command),
		.push_word (push_word),
		.position  (position),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.resp      (resp)
	);

	deq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (WORD_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1 <= resp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// RAM read data stays put while stage 1 waits, as no new read is issued.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_q      <= resp_s1.is_read ? deq_pkg::DATA_OUT_W'(mem_rdata) : '0;
			status_q    <= resp_s1.status;
			occupancy_q <= resp_s1.occupancy;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign data_out  = data_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

endmodule

`default_nettype wire

// ----- design/deq_checker.sv -----
// ---------------------------------------------------------------------------
// Deque port checker
// Watches the response channel of the double-ended queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_assert.svh"

module deq_checker #(
	parameter int DEPTH = 256
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [deq_pkg::DATA_OUT_W-1:0]    data_out,
	input wire deq_pkg::status_t                  status,
	input wire logic [deq_pkg::OCCUPANCY_W-1:0]   occupancy
);

	logic fail_empty, fail_full, fail_range, rsp_stall;

	assign fail_empty = rsp_valid && (status == deq_pkg::ST_EMPTY);
	assign fail_full  = rsp_valid && (status == deq_pkg::ST_FULL);
	assign fail_range = rsp_valid && (status == deq_pkg::ST_RANGE);
	assign rsp_stall  = rsp_valid && !rsp_ready;

	// A refused pop can only come from an empty queue, and returns no word.
	`DEQ_ASSERT_NOW(a_empty_pop, clk, arst_n, fail_empty, (occupancy == '0) && (data_out == '0))

	// A refused push reports a queue that is exactly full.
	`DEQ_ASSERT_NOW(a_full_push, clk, arst_n, fail_full, occupancy == deq_pkg::OCCUPANCY_W'(DEPTH))

	// An out-of-range read returns no word.
	`DEQ_ASSERT_NOW(a_range_zero, clk, arst_n, fail_range, data_out == '0)

	// A stalled response holds its word and occupancy.
	`DEQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(data_out) && $stable(occupancy))

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire

// ----- tb/double_ended_queue_test.sv -----
// ---------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, indexed read and unassigned commands through the command
// channel and checks every response against a ring-buffer prediction kept
// in the testbench. Random fill, drain and balanced phases take the queue
// from empty to full and back, with random gaps on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_test;

	localparam int DEPTH        = 256;
	localparam int RANDOM_ITEMS = 1125;
	localparam int FILL_LEN     = 360;
	localparam int BALANCE_LEN  = 100;
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 200000;

	localparam deq_pkg::cmd_t CMD_SPARE_FIRST = 3'd5;
	localparam deq_pkg::cmd_t CMD_SPARE_LAST  = 3'd7;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

	typedef struct packed {
		logic [deq_pkg::DATA_OUT_W-1:0]  data;
		deq_pkg::status_t                status;
		logic [deq_pkg::OCCUPANCY_W-1:0] occupancy;
	} deq_expect_t;

	// Mirrors the queue contents and holds the responses still owed.
	class deque_scoreboard;
		logic [deq_pkg::DATA_OUT_W-1:0] ring [DEPTH];
		logic [7:0]            head_slot;
		int unsigned           held;
		deq_expect_t           awaited [$];
		int unsigned           errors;
		int unsigned           checked;
		int unsigned           peak;
		int unsigned           spare_seen;
		int unsigned           by_status [4];

		function new();
			head_slot  = '0;
			held       = 0;
			errors     = 0;
			checked    = 0;
			peak       = 0;
			spare_seen = 0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_command(deq_pkg::cmd_t c, logic [deq_pkg::PUSH_W-1:0] w,
				logic [deq_pkg::POSITION_W-1:0] p);
			deq_expect_t e;
			logic [7:0]  slot;
			e.data   = '0;
			e.status = deq_pkg::ST_OK;
			case (c)
			deq_pkg::CMD_PUSH_HEAD: begin
				if (held >= DEPTH) begin
					e.status = deq_pkg::ST_FULL;
				end else begin
					head_slot       = head_slot - 8'd1;
					ring[head_slot] = w;
					held++;
				end
			end
			deq_pkg::CMD_PUSH_TAIL: begin
				if (held >= DEPTH) begin
					e.status = deq_pkg::ST_FULL;
				end else begin
					slot       = head_slot + 8'(held);
					ring[slot] = w;
					held++;
				end
			end
			deq_pkg::CMD_POP_HEAD: begin
				if (held == 0) begin
					e.status = deq_pkg::ST_EMPTY;
				end else begin
					e.data    = ring[head_slot];
					head_slot = head_slot + 8'd1;
					held--;
				end
			end
			deq_pkg::CMD_POP_TAIL: begin
				if (held == 0) begin
					e.status = deq_pkg::ST_EMPTY;
				end else begin
					slot   = head_slot + 8'(held - 1);
					e.data = ring[slot];
					held--;
				end
			end
			deq_pkg::CMD_READ: begin
				if (p >= held) begin
					e.status = deq_pkg::ST_RANGE;
				end else begin
					slot   = head_slot + p;
					e.data = ring[slot];
				end
			end
			default: begin
				spare_seen++;
			end
			endcase
			e.occupancy = 9'(held);
			if (held > peak) peak = held;
			awaited.push_back(e);
		endfunction

		function void check_response(logic [deq_pkg::DATA_OUT_W-1:0] d, deq_pkg::status_t s,
				logic [deq_pkg::OCCUPANCY_W-1:0] o);
			deq_expect_t e;
			if (awaited.size() == 0) begin
				$display("%0t: response with no command outstanding: %s %h %0d %0d",
					$time, "data, status, occupancy", d, s, o);
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			by_status[s]++;
			if (d !== e.data) begin
				$display("%0t: data_out expected %h, got %h", $time, e.data, d);
				errors++;
			end
			if (s !== e.status) begin
				$display("%0t: status expected %0d, got %0d", $time, e.status, s);
				errors++;
			end
			if (o !== e.occupancy) begin
				$display("%0t: occupancy expected %0d, got %0d", $time, e.occupancy, o);
				errors++;
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cmd_valid = 1'b0;
	logic                            cmd_ready;
	deq_pkg::cmd_t                   command = deq_pkg::CMD_PUSH_HEAD;
	logic [deq_pkg::PUSH_W-1:0]      push_word = '0;
	logic [deq_pkg::POSITION_W-1:0]  position = '0;
	logic                            rsp_valid;
	logic                            rsp_ready = 1'b0;
	logic [deq_pkg::DATA_OUT_W-1:0]  data_out;
	deq_pkg::status_t                status;
	logic [deq_pkg::OCCUPANCY_W-1:0] occupancy;

	logic        gaps_on = 1'b1;
	int unsigned cycles = 0;

	deque_scoreboard sb = new();

	double_ended_queue #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.push_word(push_word),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.data_out(data_out),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Commands are noted before responses are checked, so ordering within
	// an edge never matters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) sb.note_command(command, push_word, position);
			if (rsp_valid && rsp_ready) sb.check_response(data_out, status, occupancy);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("double_ended_queue verification failed");
			$finish;
		end
	end

	// Response side stalls in random bursts while gaps are enabled.
	initial begin
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	// Entered and left at a falling edge.
	task automatic issue(input deq_pkg::cmd_t c, input logic [deq_pkg::PUSH_W-1:0] w,
			input logic [deq_pkg::POSITION_W-1:0] p);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= c;
		push_word <= w;
		position  <= p;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	task automatic random_command(input mix_t mix);
		int unsigned                    r;
		deq_pkg::cmd_t                  c;
		logic [deq_pkg::POSITION_W-1:0] p;
		r = $urandom_range(0, 99);
		case (mix)
		MIX_FILL: begin
			if (r < 46) c = deq_pkg::CMD_PUSH_HEAD;
			else if (r < 92) c = deq_pkg::CMD_PUSH_TAIL;
			else if (r < 95) c = $urandom_range(0, 1) ? deq_pkg::CMD_POP_HEAD
			                                          : deq_pkg::CMD_POP_TAIL;
			else if (r < 99) c = deq_pkg::CMD_READ;
			else c = deq_pkg::cmd_t'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end
		MIX_DRAIN: begin
			if (r < 46) c = deq_pkg::CMD_POP_HEAD;
			else if (r < 92) c = deq_pkg::CMD_POP_TAIL;
			else if (r < 95) c = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_HEAD
			                                          : deq_pkg::CMD_PUSH_TAIL;
			else if (r < 99) c = deq_pkg::CMD_READ;
			else c = deq_pkg::cmd_t'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end
		default: begin
			if (r < 20) c = deq_pkg::CMD_PUSH_HEAD;
			else if (r < 40) c = deq_pkg::CMD_PUSH_TAIL;
			else if (r < 58) c = deq_pkg::CMD_POP_HEAD;
			else if (r < 76) c = deq_pkg::CMD_POP_TAIL;
			else if (r < 95) c = deq_pkg::CMD_READ;
			else c = deq_pkg::cmd_t'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end
		endcase
		// Mostly live positions, otherwise anything the field can hold.
		if (sb.held != 0 && $urandom_range(0, 3) != 0) p = 8'($urandom_range(0, sb.held - 1));
		else p = 8'($urandom);
		issue(c, $urandom, p);
	endtask

	initial begin
		mix_t mix;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty queue: both pops and reads must be refused.
		issue(deq_pkg::CMD_POP_HEAD, 32'h0, 8'h00);
		issue(deq_pkg::CMD_POP_TAIL, 32'hFFFF_FFFF, 8'hFF);
		issue(deq_pkg::CMD_READ, 32'h0, 8'h00);
		issue(deq_pkg::CMD_READ, 32'h0, 8'hFF);
		// The first head push wraps the head slot below zero.
		issue(deq_pkg::CMD_PUSH_TAIL, 32'h0000_0000, 8'h00);
		issue(deq_pkg::CMD_PUSH_HEAD, 32'hFFFF_FFFF, 8'h00);
		issue(deq_pkg::CMD_PUSH_TAIL, 32'hA5A5_A5A5, 8'hFF);
		issue(deq_pkg::CMD_PUSH_HEAD, 32'h5A5A_5A5A, 8'h00);
		issue(deq_pkg::CMD_READ, 32'h0, 8'h00);
		issue(deq_pkg::CMD_READ, 32'h0, 8'h03);
		issue(deq_pkg::CMD_READ, 32'h0, 8'h04);
		issue(deq_pkg::CMD_READ, 32'h0, 8'hFF);
		for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++) begin
			issue(deq_pkg::cmd_t'(k), $urandom, 8'($urandom));
		end
		issue(deq_pkg::CMD_POP_TAIL, 32'h0, 8'h00);
		issue(deq_pkg::CMD_POP_HEAD, 32'h0, 8'h00);
		issue(deq_pkg::CMD_POP_TAIL, 32'h0, 8'h00);
		// Last element leaves from the head, then from the tail.
		issue(deq_pkg::CMD_POP_HEAD, 32'h0, 8'h00);
		issue(deq_pkg::CMD_POP_HEAD, 32'h0, 8'h00);
		issue(deq_pkg::CMD_PUSH_HEAD, 32'h8000_0001, 8'h00);
		issue(deq_pkg::CMD_POP_TAIL, 32'h0, 8'h00);
		issue(deq_pkg::CMD_PUSH_TAIL, 32'h0000_0001, 8'h00);
		issue(deq_pkg::CMD_READ, 32'h0, 8'h00);
		issue(deq_pkg::CMD_POP_HEAD, 32'h0, 8'h00);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// Once the queue has been filled, hold off until every response is in.
			if (k == FILL_LEN) begin
				cmd_valid <= 1'b0;
				@(negedge clk);
				while (sb.pending() != 0) @(negedge clk);
			end
			if (k == RANDOM_ITEMS - QUIET_TAIL) gaps_on <= 1'b0;
			if (k < FILL_LEN) mix = MIX_FILL;
			else if (k < FILL_LEN + BALANCE_LEN) mix = MIX_BALANCED;
			else if (k < 2 * FILL_LEN + BALANCE_LEN) mix = MIX_DRAIN;
			else if (k < 2 * (FILL_LEN + BALANCE_LEN)) mix = MIX_BALANCED;
			else mix = MIX_FILL;
			random_command(mix);
		end

		cmd_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d responses: %0d ok, %0d empty pops, %0d full pushes,",
			sb.checked, sb.by_status[deq_pkg::ST_OK], sb.by_status[deq_pkg::ST_EMPTY],
			sb.by_status[deq_pkg::ST_FULL]);
		$display("%0d reads out of range; occupancy peaked at %0d of %0d; %0d spare codes sent.",
			sb.by_status[deq_pkg::ST_RANGE], sb.peak, DEPTH, sb.spare_seen);
		if (sb.errors == 0) begin
			$display("double_ended_queue verification clean");
		end else begin
			$display("double_ended_queue verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
design/deq_checker.sv
tb/double_ended_queue_test.sv
